// ----- src/dlet_pkg.sv -----
// dlet_pkg: types and constants for the delta list event timer
// used by dlet_front, dlet_list and delta_list_event_timer
package dlet_pkg;

   localparam int LIST_DEPTH_DEFAULT = 16;
   localparam int MAX_RESULTS = 16;
   localparam int DELTA_W = 35;
   localparam int NS_PER_US = 1000;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_ADD    = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic {
      KIND_DUE    = 1'b0,
      KIND_REJECT = 1'b1
   } kind_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  owner_id;
      logic [31:0] event_data;
      logic [31:0] event_context;
      logic [23:0] delay_us;
      logic [31:0] elapsed_ns;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  due_owner;
      logic [31:0] due_data;
      logic [31:0] due_context;
      logic        last;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      mode_type           mode;
      logic [7:0]         owner;
      logic [31:0]        data;
      logic [31:0]        context_w;
      logic [DELTA_W-1:0] amount;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_ADD_FIND,
      ST_ADD_SHIFT,
      ST_REM,
      ST_DRAIN
   } state_type;

endpackage

// ----- src/delta_list_event_timer.sv -----
// delta_list_event_timer: top level of the delta list event timer
// depends on dlet_pkg, dlet_front, dlet_list
//
// channel   ports                       transfer
// request   start, busy, req            start && !busy
// response  rsp_strobe, rsp             rsp_strobe, one cycle, no stall
//
// a command waits in the front queue until the list sequencer is idle, then holds
// the list sequencer for the one-entry-per-cycle list walk; tick results
// come one per cycle
// the front queue holds two commands; busy rises only when it is full
// reset clears the list count and the queue; no clearing pass is needed
// the receiver cannot stall, results are shown for exactly one cycle
module delta_list_event_timer #(
   parameter int LIST_DEPTH = dlet_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dlet_pkg::req_type req,
   output logic              rsp_strobe,
   output dlet_pkg::rsp_type rsp
);

   logic              cmd_valid, cmd_take;
   dlet_pkg::cmd_type cmd;

   dlet_front u_front (
      .clock(clock), .reset(reset), .start(start), .req(req), .busy(busy),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
   );

   dlet_list #(.LIST_DEPTH(LIST_DEPTH)) u_list (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd(cmd),
      .cmd_take(cmd_take), .rsp_strobe(rsp_strobe), .rsp(rsp)
   );

endmodule

// ----- src/dlet_front.sv -----
// dlet_front: accepts commands, converts delay to ns, two-entry queue
// depends on dlet_pkg
module dlet_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  dlet_pkg::req_type req,
   output logic             busy,
   output logic             cmd_valid,
   output dlet_pkg::cmd_type cmd,
   input  logic             cmd_take
);

   dlet_pkg::cmd_type q_ff [2];
   dlet_pkg::cmd_type q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push;
   logic [33:0] ns;

   // us to ns: x*1000 = x*1024 - x*16 - x*8
   assign ns = ({10'd0, req.delay_us} << 10) - ({10'd0, req.delay_us} << 4)
             - ({10'd0, req.delay_us} << 3);

   assign busy = cnt_ff[1];
   assign push = start && !busy && req.mode != dlet_pkg::MODE_NONE;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd = q_ff[rd_ff];

   always_comb begin
      q_in.mode = dlet_pkg::mode_type'(req.mode);
      q_in.owner = req.owner_id;
      q_in.data = req.event_data;
      q_in.context_w = req.event_context;
      if (req.mode == dlet_pkg::MODE_ADD) begin
         q_in.amount = {1'b0, ns};
      end else begin
         q_in.amount = {3'd0, req.elapsed_ns};
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, cmd_take};
      rd_in = rd_ff ^ cmd_take;
      wr_in = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) begin
         q_ff[wr_ff] <= q_in;
      end
   end

`ifndef SYNTHESIS
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_no_under: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid) else $error("queue underflow");
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("bad count");
`endif

endmodule

// ----- src/dlet_list.sv -----
// dlet_list: delta list storage and sequencer for tick, add and remove
// depends on dlet_pkg
module dlet_list #(
   parameter int LIST_DEPTH = dlet_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  dlet_pkg::cmd_type cmd,
   output logic              cmd_take,
   output logic              rsp_strobe,
   output dlet_pkg::rsp_type rsp
);

   localparam int IW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int DW = dlet_pkg::DELTA_W;
   localparam int RW = $clog2(dlet_pkg::MAX_RESULTS + 1);

   logic [7:0]    own_ff [LIST_DEPTH];
   logic [31:0]   dat_ff [LIST_DEPTH];
   logic [31:0]   ctx_ff [LIST_DEPTH];
   logic [DW-1:0] dlt_ff [LIST_DEPTH];

   dlet_pkg::state_type st_ff, st_in;
   dlet_pkg::cmd_type   c_ff, c_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] w_ff, w_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic [DW-1:0] carry_ff, carry_in;
   logic [RW-1:0] n_ff, n_in;
   logic          str_ff, str_in;
   dlet_pkg::rsp_type r_ff, r_in;

   logic [IW-1:0] ix, wx, ixm;
   logic [DW-1:0] cur, sum;
   logic          in_rng, due, more;

   assign ix  = i_ff[IW-1:0];
   assign wx  = w_ff[IW-1:0];
   assign ixm = IW'(i_ff - CW'(1));
   assign in_rng = i_ff < cnt_ff;
   assign cur = dlt_ff[ix];
   assign sum = acc_ff + cur;
   assign due = cur <= c_ff.amount;
   assign more = (i_ff + CW'(1) < cnt_ff) && n_ff + RW'(1) < RW'(dlet_pkg::MAX_RESULTS)
               && dlt_ff[IW'(i_ff + CW'(1))] <= c_ff.amount - cur;
   assign cmd_take = st_ff == dlet_pkg::ST_IDLE && cmd_valid;
   assign rsp_strobe = str_ff;
   assign rsp = r_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         dlet_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.mode)
                  dlet_pkg::MODE_TICK: st_in = dlet_pkg::ST_TICK;
                  dlet_pkg::MODE_ADD: st_in = dlet_pkg::ST_ADD_FIND;
                  dlet_pkg::MODE_REMOVE: st_in = dlet_pkg::ST_REM;
                  default: st_in = dlet_pkg::ST_IDLE;
               endcase
            end
         end
         dlet_pkg::ST_TICK: begin
            if (!(in_rng && n_ff < RW'(dlet_pkg::MAX_RESULTS) && due)) begin
               st_in = dlet_pkg::ST_DRAIN;
            end
         end
         dlet_pkg::ST_ADD_FIND: begin
            if (cnt_ff >= CW'(LIST_DEPTH)) begin
               st_in = dlet_pkg::ST_IDLE;
            end else if (!(in_rng && !(c_ff.amount < sum))) begin
               st_in = dlet_pkg::ST_ADD_SHIFT;
            end
         end
         dlet_pkg::ST_ADD_SHIFT: begin
            if (i_ff == w_ff) begin
               st_in = dlet_pkg::ST_IDLE;
            end
         end
         dlet_pkg::ST_REM: begin
            if (!in_rng) begin
               st_in = dlet_pkg::ST_IDLE;
            end
         end
         dlet_pkg::ST_DRAIN: begin
            if (i_ff == '0 || !in_rng || w_ff == cnt_ff - i_ff) begin
               st_in = dlet_pkg::ST_IDLE;
            end
         end
         default: st_in = dlet_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      c_in = c_ff;
      cnt_in = cnt_ff;
      i_in = i_ff;
      w_in = w_ff;
      acc_in = acc_ff;
      carry_in = carry_ff;
      n_in = n_ff;
      str_in = 1'b0;
      r_in = r_ff;
      unique case (st_ff)
         dlet_pkg::ST_IDLE: begin
            c_in = cmd;
            i_in = '0;
            w_in = '0;
            acc_in = '0;
            carry_in = '0;
            n_in = '0;
         end
         dlet_pkg::ST_TICK: begin
            if (in_rng && n_ff < RW'(dlet_pkg::MAX_RESULTS) && due) begin
               c_in.amount = c_ff.amount - cur;
               str_in = 1'b1;
               r_in.result_kind = dlet_pkg::KIND_DUE;
               r_in.due_owner = own_ff[ix];
               r_in.due_data = dat_ff[ix];
               r_in.due_context = ctx_ff[ix];
               r_in.last = !more;
               i_in = i_ff + CW'(1);
               n_in = n_ff + RW'(1);
            end
         end
         dlet_pkg::ST_DRAIN: begin
            // compact remaining entries down by i places, w counts moved
            if (i_ff == '0 || !in_rng) begin
               cnt_in = cnt_ff - i_ff;
            end else if (w_ff == cnt_ff - i_ff) begin
               cnt_in = cnt_ff - i_ff;
            end else begin
               w_in = w_ff + CW'(1);
            end
         end
         dlet_pkg::ST_ADD_FIND: begin
            if (cnt_ff >= CW'(LIST_DEPTH)) begin
               str_in = 1'b1;
               r_in.result_kind = dlet_pkg::KIND_REJECT;
               r_in.due_owner = c_ff.owner;
               r_in.due_data = c_ff.data;
               r_in.due_context = c_ff.context_w;
               r_in.last = 1'b1;
            end else if (in_rng && !(c_ff.amount < sum)) begin
               acc_in = sum;
               i_in = i_ff + CW'(1);
            end else begin
               c_in.amount = c_ff.amount - acc_ff;
               w_in = i_ff;
               i_in = cnt_ff;
            end
         end
         dlet_pkg::ST_ADD_SHIFT: begin
            if (i_ff == w_ff) begin
               cnt_in = cnt_ff + CW'(1);
            end else begin
               i_in = i_ff - CW'(1);
            end
         end
         dlet_pkg::ST_REM: begin
            if (in_rng) begin
               i_in = i_ff + CW'(1);
               if (own_ff[ix] == c_ff.owner) begin
                  carry_in = carry_ff + cur;
               end else begin
                  carry_in = '0;
                  w_in = w_ff + CW'(1);
               end
            end else begin
               cnt_in = w_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= dlet_pkg::ST_IDLE;
         cnt_ff <= '0;
         str_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         str_ff <= str_in;
      end
      c_ff <= c_in;
      i_ff <= i_in;
      w_ff <= w_in;
      acc_ff <= acc_in;
      carry_ff <= carry_in;
      n_ff <= n_in;
      r_ff <= r_in;
   end

   // list memory writes, one entry per cycle
   always_ff @(posedge clock) begin
      unique case (st_ff)
         dlet_pkg::ST_TICK: begin
            if (!(in_rng && n_ff < RW'(dlet_pkg::MAX_RESULTS) && due) && in_rng) begin
               if (cur > c_ff.amount) begin
                  dlt_ff[ix] <= cur - c_ff.amount;
               end else begin
                  dlt_ff[ix] <= '0;
               end
            end
         end
         dlet_pkg::ST_DRAIN: begin
            if (i_ff != '0 && in_rng && w_ff != cnt_ff - i_ff) begin
               own_ff[wx] <= own_ff[IW'(w_ff + i_ff)];
               dat_ff[wx] <= dat_ff[IW'(w_ff + i_ff)];
               ctx_ff[wx] <= ctx_ff[IW'(w_ff + i_ff)];
               dlt_ff[wx] <= dlt_ff[IW'(w_ff + i_ff)];
            end
         end
         dlet_pkg::ST_ADD_FIND: begin
            if (cnt_ff < CW'(LIST_DEPTH) && !(in_rng && !(c_ff.amount < sum)) && in_rng) begin
               dlt_ff[ix] <= cur - (c_ff.amount - acc_ff);
            end
         end
         dlet_pkg::ST_ADD_SHIFT: begin
            if (i_ff == w_ff) begin
               own_ff[ix] <= c_ff.owner;
               dat_ff[ix] <= c_ff.data;
               ctx_ff[ix] <= c_ff.context_w;
               dlt_ff[ix] <= c_ff.amount;
            end else begin
               own_ff[ix] <= own_ff[ixm];
               dat_ff[ix] <= dat_ff[ixm];
               ctx_ff[ix] <= ctx_ff[ixm];
               dlt_ff[ix] <= dlt_ff[ixm];
            end
         end
         dlet_pkg::ST_REM: begin
            if (in_rng && own_ff[ix] != c_ff.owner) begin
               own_ff[wx] <= own_ff[ix];
               dat_ff[wx] <= dat_ff[ix];
               ctx_ff[wx] <= ctx_ff[ix];
               dlt_ff[wx] <= cur + carry_ff;
            end
         end
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_cnt_rng: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(LIST_DEPTH)) else $error("count beyond depth");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> st_ff == dlet_pkg::ST_IDLE) else $error("take while working");
   a_rej_full: assert property (@(posedge clock) disable iff (reset)
      str_ff && r_ff.result_kind == dlet_pkg::KIND_REJECT |-> r_ff.last)
      else $error("reject not last");
`endif

endmodule
